/* design/euler_camera_pose_update_assert.svh */
// assertion macros used by the checker file
`ifndef EULER_CAMERA_POSE_UPDATE_ASSERT_SVH
`define EULER_CAMERA_POSE_UPDATE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ECPU_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("ecpu assertion failed");

// next-cycle implication, disabled in reset
`define ECPU_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("ecpu assertion failed");

// next-cycle implication, checked during reset too
`define ECPU_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("ecpu assertion failed");

`endif

/* design/ecpu_pkg.sv */
// types, constants and helper functions of the camera pose block
`default_nettype none
package ecpu_pkg;

   localparam int ANGLE_FRAC_BITS   = 8;
   localparam int POS_FRAC_BITS     = 16;
   localparam int CORDIC_ITERATIONS = 16;

   localparam int CORD_SHIFT  = 20 - ANGLE_FRAC_BITS;
   localparam int MOUSE_SHIFT = 20 - ANGLE_FRAC_BITS;
   localparam int SCROLL_SHIFT = ANGLE_FRAC_BITS - 4;
   localparam int MOVE_SHIFT  = 30 - POS_FRAC_BITS;

   localparam logic signed [22:0] YAW_SPAN    = 23'(360 << ANGLE_FRAC_BITS);
   localparam logic signed [22:0] YAW_HALF    = 23'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [22:0] YAW_QUARTER = 23'(90 << ANGLE_FRAC_BITS);
   localparam logic signed [22:0] PITCH_LIM   = 23'(89 << ANGLE_FRAC_BITS);
   localparam logic signed [22:0] ZOOM_MIN    = 23'(1 << ANGLE_FRAC_BITS);
   localparam logic signed [22:0] ZOOM_MAX    = 23'(45 << ANGLE_FRAC_BITS);
   localparam logic [13:0]        ZOOM_RESET  = 14'(40 << ANGLE_FRAC_BITS);
   localparam logic signed [16:0] YAW_RESET   = -17'(90 << ANGLE_FRAC_BITS);

   localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

   localparam logic [7:0]  SPEED_RESET = 8'd30;
   localparam logic [15:0] SENS_RESET  = 16'd3277;

   typedef enum logic [1:0] {
      CMD_MOUSE   = 2'd0,
      CMD_SCROLL  = 2'd1,
      CMD_KEY     = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   localparam logic [2:0] DIR_FORWARD  = 3'd0;
   localparam logic [2:0] DIR_BACKWARD = 3'd1;
   localparam logic [2:0] DIR_RIGHT    = 3'd2;
   localparam logic [2:0] DIR_LEFT     = 3'd3;
   localparam logic [2:0] DIR_UP       = 3'd4;
   localparam logic [2:0] DIR_DOWN     = 3'd5;

   localparam logic [2:0] REG_MOVE_SPEED = 3'd0;
   localparam logic [2:0] REG_SENS       = 3'd1;
   localparam logic [2:0] REG_FPS_MODE   = 3'd2;
   localparam logic [2:0] REG_START_X    = 3'd3;
   localparam logic [2:0] REG_START_Y    = 3'd4;
   localparam logic [2:0] REG_START_Z    = 3'd5;

   typedef logic signed [41:0] prod_type;

   function automatic prod_type rnd_shift(input prod_type v, input int s);
      prod_type half;
      half = 42'sd1 <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [15:0] sat_q14(input prod_type v);
      prod_type r;
      r = rnd_shift(v, 14);
      if (r > 42'sd16384) return 16'sd16384;
      if (r < -42'sd16384) return -16'sd16384;
      return 16'(r);
   endfunction

   // atan(2^-i) in degrees, Q.20
   function automatic logic signed [27:0] atan_q20(input logic [4:0] i);
      case (i)
         5'd0:  return 28'sd47185920;
         5'd1:  return 28'sd27855475;
         5'd2:  return 28'sd14718068;
         5'd3:  return 28'sd7471121;
         5'd4:  return 28'sd3750058;
         5'd5:  return 28'sd1876857;
         5'd6:  return 28'sd938658;
         5'd7:  return 28'sd469357;
         5'd8:  return 28'sd234682;
         5'd9:  return 28'sd117342;
         5'd10: return 28'sd58671;
         5'd11: return 28'sd29335;
         5'd12: return 28'sd14668;
         5'd13: return 28'sd7334;
         5'd14: return 28'sd3667;
         5'd15: return 28'sd1833;
         5'd16: return 28'sd917;
         5'd17: return 28'sd458;
         5'd18: return 28'sd229;
         5'd19: return 28'sd115;
         5'd20: return 28'sd57;
         5'd21: return 28'sd29;
         5'd22: return 28'sd14;
         5'd23: return 28'sd7;
         default: return 28'sd0;
      endcase
   endfunction

endpackage
`default_nettype wire

/* design/ecpu_if.sv */
// request and response channel interfaces of the camera pose block
`default_nettype none
interface ecpu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [15:0] dx;
   logic signed [15:0] dy;
   logic [15:0]        delta_time;
   logic [2:0]         direction;
   modport source (output valid, cmd, dx, dy, delta_time, direction, input ready);
   modport sink (input valid, cmd, dx, dy, delta_time, direction, output ready);
endinterface

interface ecpu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [15:0] front_x;
   logic signed [15:0] front_y;
   logic signed [15:0] front_z;
   logic [13:0]        zoom_deg;
   logic signed [15:0] pitch_deg;
   logic signed [16:0] yaw_deg;
   modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                   zoom_deg, pitch_deg, yaw_deg, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                 zoom_deg, pitch_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

/* design/euler_camera_pose_update.sv */
// first-person camera pose keeper: yaw/pitch, zoom, position and view vectors
//
// req_ch carries one event per transfer (mouse, scroll, key move, restart);
// rsp_ch returns one pose per event, after the update. Both are valid/ready.
// csr_* is an APB-style register port, registers at byte address 4*i,
// pready tied high. The user must see that registers are written only
// while the block is idle; the block does not enforce this. One event is
// in work at a time. Products go through one shift-add multiplier, one bit
// of the multiplier operand per cycle; sin/cos come from one CORDIC unit,
// one iteration per cycle. Work per request, in order:
//   mouse   two multiplies, yaw wrap steps, two CORDIC passes, two multiplies
//   scroll  two CORDIC passes, two multiplies
//   key     one multiply, then one multiply per moved axis (none per skipped axis)
//   restart none; the restart pose is loaded directly
// A finished pose waits in the output register while the next request is
// taken; if the receiver stalls, the following pose waits in the sequencer.
// Reset (synchronous) loads register defaults, yaw -90, pitch 0, zoom 40,
// position zero, front (0,0,-1), right (1,0) and drops any pending response.
`default_nettype none
module euler_camera_pose_update (
   input  wire logic        clock,
   input  wire logic        reset,
   ecpu_req_if.sink         req_ch,
   ecpu_rsp_if.source       rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_MX, ST_MY, ST_WRAP, ST_VEC, ST_CORD, ST_CDONE,
      ST_F0, ST_F2, ST_KV, ST_KAX, ST_KUP, ST_DONE
   } state_type;

   localparam logic [4:0] MUL_LAST  = 5'd24;
   localparam logic [4:0] CORD_LAST = 5'(ecpu_pkg::CORDIC_ITERATIONS - 1);
   localparam logic [1:0] AXIS_END  = 2'd3;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [7:0]         speed_ff, speed_in;
   logic [15:0]        sens_ff, sens_in;
   logic               fps_ff, fps_in;
   logic signed [31:0] startx_ff, startx_in, starty_ff, starty_in, startz_ff, startz_in;

   logic signed [16:0] yaw_ff, yaw_in;
   logic signed [15:0] pitch_ff, pitch_in;
   logic [13:0]        zoom_ff, zoom_in;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [15:0] front_ff [3];
   logic signed [15:0] front_in [3];
   logic signed [15:0] right_ff [2];
   logic signed [15:0] right_in [2];

   logic signed [15:0] dy_ff, dy_in;
   logic [2:0]         dir_ff, dir_in;

   ecpu_pkg::prod_type acc_ff, acc_in, ash_ff, ash_in;
   logic [24:0]        bsh_ff, bsh_in;
   logic [4:0]         mcnt_ff, mcnt_in;

   logic signed [22:0] wr_ff, wr_in;

   logic signed [31:0] cx_ff, cx_in, cyv_ff, cyv_in;
   logic signed [29:0] cz_ff, cz_in;
   logic [4:0]         it_ff, it_in;
   logic               cpass_ff, cpass_in, neg_ff, neg_in;
   logic signed [15:0] cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;

   logic [23:0]        vel_ff, vel_in;
   logic [1:0]         axis_ff, axis_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] opos_ff [3];
   logic signed [31:0] opos_in [3];
   logic signed [15:0] ofront_ff [3];
   logic signed [15:0] ofront_in [3];
   logic [13:0]        ozoom_ff, ozoom_in;
   logic signed [15:0] opitch_ff, opitch_in;
   logic signed [16:0] oyaw_ff, oyaw_in;

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pos_x     = opos_ff[0];
   assign rsp_ch.pos_y     = opos_ff[1];
   assign rsp_ch.pos_z     = opos_ff[2];
   assign rsp_ch.front_x   = ofront_ff[0];
   assign rsp_ch.front_y   = ofront_ff[1];
   assign rsp_ch.front_z   = ofront_ff[2];
   assign rsp_ch.zoom_deg  = ozoom_ff;
   assign rsp_ch.pitch_deg = opitch_ff;
   assign rsp_ch.yaw_deg   = oyaw_ff;
   assign csr_pready       = 1'b1;

   always_comb begin
      case (csr_paddr[4:2])
         ecpu_pkg::REG_MOVE_SPEED: csr_prdata = 32'(speed_ff);
         ecpu_pkg::REG_SENS:       csr_prdata = 32'(sens_ff);
         ecpu_pkg::REG_FPS_MODE:   csr_prdata = 32'(fps_ff);
         ecpu_pkg::REG_START_X:    csr_prdata = startx_ff;
         ecpu_pkg::REG_START_Y:    csr_prdata = starty_ff;
         ecpu_pkg::REG_START_Z:    csr_prdata = startz_ff;
         default:                  csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      logic signed [22:0] ox, oy, pnew, ztmp, ang;
      logic signed [31:0] xs, ys;
      logic signed [15:0] vc, vs, unit;
      logic               en;
      ecpu_pkg::prod_type d, p;

      ox = '0; oy = '0; pnew = '0; ztmp = '0; ang = '0;
      xs = '0; ys = '0; vc = '0; vs = '0; unit = '0; en = 1'b0; d = '0; p = '0;

      state_in = state_ff; ret_in = ret_ff;
      speed_in = speed_ff; sens_in = sens_ff; fps_in = fps_ff;
      startx_in = startx_ff; starty_in = starty_ff; startz_in = startz_ff;
      yaw_in = yaw_ff; pitch_in = pitch_ff; zoom_in = zoom_ff;
      pos_in = pos_ff; front_in = front_ff; right_in = right_ff;
      dy_in = dy_ff; dir_in = dir_ff;
      acc_in = acc_ff; ash_in = ash_ff; bsh_in = bsh_ff; mcnt_in = mcnt_ff;
      wr_in = wr_ff;
      cx_in = cx_ff; cyv_in = cyv_ff; cz_in = cz_ff; it_in = it_ff;
      cpass_in = cpass_ff; neg_in = neg_ff;
      cy_in = cy_ff; sy_in = sy_ff; cp_in = cp_ff; sp_in = sp_ff;
      vel_in = vel_ff; axis_in = axis_ff;
      opos_in = opos_ff; ofront_in = ofront_ff;
      ozoom_in = ozoom_ff; opitch_in = opitch_ff; oyaw_in = oyaw_ff;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[4:2])
            ecpu_pkg::REG_MOVE_SPEED: speed_in = csr_pwdata[7:0];
            ecpu_pkg::REG_SENS:       sens_in = csr_pwdata[15:0];
            ecpu_pkg::REG_FPS_MODE:   fps_in = csr_pwdata[0];
            ecpu_pkg::REG_START_X:    startx_in = csr_pwdata;
            ecpu_pkg::REG_START_Y:    starty_in = csr_pwdata;
            ecpu_pkg::REG_START_Z:    startz_in = csr_pwdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               dy_in  = req_ch.dy;
               dir_in = req_ch.direction;
               acc_in = '0;
               mcnt_in = '0;
               case (req_ch.cmd)
                  ecpu_pkg::CMD_MOUSE: begin
                     ash_in   = 42'(req_ch.dx);
                     bsh_in   = 25'(sens_ff);
                     ret_in   = ST_MX;
                     state_in = ST_MUL;
                  end
                  ecpu_pkg::CMD_SCROLL: begin
                     ztmp = 23'(signed'({1'b0, zoom_ff}))
                          - (23'(req_ch.dy) <<< ecpu_pkg::SCROLL_SHIFT);
                     if (ztmp < ecpu_pkg::ZOOM_MIN) ztmp = ecpu_pkg::ZOOM_MIN;
                     else if (ztmp > ecpu_pkg::ZOOM_MAX) ztmp = ecpu_pkg::ZOOM_MAX;
                     zoom_in  = 14'(ztmp);
                     state_in = ST_VEC;
                  end
                  ecpu_pkg::CMD_KEY: begin
                     ash_in   = 42'(speed_ff);
                     bsh_in   = 25'(req_ch.delta_time);
                     ret_in   = ST_KV;
                     state_in = ST_MUL;
                  end
                  default: begin
                     yaw_in      = ecpu_pkg::YAW_RESET;
                     pitch_in    = '0;
                     zoom_in     = ecpu_pkg::ZOOM_RESET;
                     pos_in[0]   = startx_ff;
                     pos_in[1]   = starty_ff;
                     pos_in[2]   = startz_ff;
                     front_in[0] = '0;
                     front_in[1] = '0;
                     front_in[2] = -ecpu_pkg::ONE_Q14;
                     right_in[0] = ecpu_pkg::ONE_Q14;
                     right_in[1] = '0;
                     state_in    = ST_DONE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            if (bsh_ff[0]) begin
               acc_in = (mcnt_ff == MUL_LAST) ? acc_ff - ash_ff : acc_ff + ash_ff;
            end
            ash_in  = ash_ff <<< 1;
            bsh_in  = bsh_ff >> 1;
            mcnt_in = mcnt_ff + 5'd1;
            if (mcnt_ff == MUL_LAST) state_in = ret_ff;
         end
         ST_MX: begin
            ox       = 23'(ecpu_pkg::rnd_shift(acc_ff, ecpu_pkg::MOUSE_SHIFT));
            wr_in    = 23'(yaw_ff) - ox + ecpu_pkg::YAW_HALF;
            ash_in   = 42'(dy_ff);
            bsh_in   = 25'(sens_ff);
            acc_in   = '0;
            mcnt_in  = '0;
            ret_in   = ST_MY;
            state_in = ST_MUL;
         end
         ST_MY: begin
            oy   = 23'(ecpu_pkg::rnd_shift(acc_ff, ecpu_pkg::MOUSE_SHIFT));
            pnew = 23'(pitch_ff) - oy;
            if (pnew > ecpu_pkg::PITCH_LIM) pnew = ecpu_pkg::PITCH_LIM;
            else if (pnew < -ecpu_pkg::PITCH_LIM) pnew = -ecpu_pkg::PITCH_LIM;
            pitch_in = 16'(pnew);
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (wr_ff < 23'sd0) wr_in = wr_ff + ecpu_pkg::YAW_SPAN;
            else if (wr_ff >= ecpu_pkg::YAW_SPAN) wr_in = wr_ff - ecpu_pkg::YAW_SPAN;
            else begin
               yaw_in   = 17'(wr_ff - ecpu_pkg::YAW_HALF);
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            ang    = 23'(yaw_ff);
            neg_in = 1'b0;
            if (ang > ecpu_pkg::YAW_QUARTER) begin
               ang    = ang - (ecpu_pkg::YAW_QUARTER <<< 1);
               neg_in = 1'b1;
            end else if (ang < -ecpu_pkg::YAW_QUARTER) begin
               ang    = ang + (ecpu_pkg::YAW_QUARTER <<< 1);
               neg_in = 1'b1;
            end
            cz_in    = 30'(ang) <<< ecpu_pkg::CORD_SHIFT;
            cx_in    = ecpu_pkg::CORDIC_GAIN;
            cyv_in   = '0;
            it_in    = '0;
            cpass_in = 1'b0;
            state_in = ST_CORD;
         end
         ST_CORD: begin
            xs = cx_ff >>> it_ff;
            ys = cyv_ff >>> it_ff;
            if (cz_ff >= 30'sd0) begin
               cx_in  = cx_ff - ys;
               cyv_in = cyv_ff + xs;
               cz_in  = cz_ff - 30'(ecpu_pkg::atan_q20(it_ff));
            end else begin
               cx_in  = cx_ff + ys;
               cyv_in = cyv_ff - xs;
               cz_in  = cz_ff + 30'(ecpu_pkg::atan_q20(it_ff));
            end
            it_in = it_ff + 5'd1;
            if (it_ff == CORD_LAST) state_in = ST_CDONE;
         end
         ST_CDONE: begin
            vc = ecpu_pkg::sat_q14(42'(cx_ff));
            vs = ecpu_pkg::sat_q14(42'(cyv_ff));
            if (!cpass_ff) begin
               cy_in    = neg_ff ? -vc : vc;
               sy_in    = neg_ff ? -vs : vs;
               cz_in    = 30'(pitch_ff) <<< ecpu_pkg::CORD_SHIFT;
               cx_in    = ecpu_pkg::CORDIC_GAIN;
               cyv_in   = '0;
               it_in    = '0;
               cpass_in = 1'b1;
               state_in = ST_CORD;
            end else begin
               cp_in    = vc;
               sp_in    = vs;
               ash_in   = 42'(cy_ff);
               bsh_in   = 25'(vc);
               acc_in   = '0;
               mcnt_in  = '0;
               ret_in   = ST_F0;
               state_in = ST_MUL;
            end
         end
         ST_F0: begin
            front_in[0] = ecpu_pkg::sat_q14(acc_ff);
            ash_in      = 42'(sy_ff);
            bsh_in      = 25'(cp_ff);
            acc_in      = '0;
            mcnt_in     = '0;
            ret_in      = ST_F2;
            state_in    = ST_MUL;
         end
         ST_F2: begin
            front_in[2] = ecpu_pkg::sat_q14(acc_ff);
            front_in[1] = sp_ff;
            right_in[0] = -sy_ff;
            right_in[1] = cy_ff;
            state_in    = ST_DONE;
         end
         ST_KV: begin
            vel_in   = acc_ff[23:0];
            axis_in  = '0;
            state_in = ST_KAX;
         end
         ST_KAX: begin
            case (dir_ff)
               ecpu_pkg::DIR_FORWARD, ecpu_pkg::DIR_BACKWARD: begin
                  en   = (axis_ff != 2'd1) || !fps_ff;
                  unit = (axis_ff == AXIS_END) ? 16'sd0 : front_ff[axis_ff];
               end
               ecpu_pkg::DIR_RIGHT, ecpu_pkg::DIR_LEFT: begin
                  en   = (axis_ff != 2'd1);
                  unit = (axis_ff == 2'd0) ? right_ff[0] : right_ff[1];
               end
               ecpu_pkg::DIR_UP, ecpu_pkg::DIR_DOWN: begin
                  en   = (axis_ff == 2'd1);
                  unit = ecpu_pkg::ONE_Q14;
               end
               default: begin
                  en   = 1'b0;
                  unit = '0;
               end
            endcase
            if (axis_ff == AXIS_END) state_in = ST_DONE;
            else if (en) begin
               ash_in   = 42'(unit);
               bsh_in   = {1'b0, vel_ff};
               acc_in   = '0;
               mcnt_in  = '0;
               ret_in   = ST_KUP;
               state_in = ST_MUL;
            end else axis_in = axis_ff + 2'd1;
         end
         ST_KUP: begin
            d = ecpu_pkg::rnd_shift(acc_ff, ecpu_pkg::MOVE_SHIFT);
            p = dir_ff[0] ? 42'(pos_ff[axis_ff]) - d : 42'(pos_ff[axis_ff]) + d;
            if (p > 42'sd2147483647) p = 42'sd2147483647;
            else if (p < -42'sd2147483648) p = -42'sd2147483648;
            pos_in[axis_ff] = 32'(p);
            axis_in  = axis_ff + 2'd1;
            state_in = ST_KAX;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               opos_in      = pos_ff;
               ofront_in    = front_ff;
               ozoom_in     = zoom_ff;
               opitch_in    = pitch_ff;
               oyaw_in      = yaw_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         speed_ff     <= ecpu_pkg::SPEED_RESET;
         sens_ff      <= ecpu_pkg::SENS_RESET;
         fps_ff       <= 1'b0;
         startx_ff    <= '0;
         starty_ff    <= '0;
         startz_ff    <= '0;
         yaw_ff       <= ecpu_pkg::YAW_RESET;
         pitch_ff     <= '0;
         zoom_ff      <= ecpu_pkg::ZOOM_RESET;
         pos_ff       <= '{default: '0};
         front_ff     <= '{16'sd0, 16'sd0, -ecpu_pkg::ONE_Q14};
         right_ff     <= '{ecpu_pkg::ONE_Q14, 16'sd0};
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         speed_ff     <= speed_in;
         sens_ff      <= sens_in;
         fps_ff       <= fps_in;
         startx_ff    <= startx_in;
         starty_ff    <= starty_in;
         startz_ff    <= startz_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         zoom_ff      <= zoom_in;
         pos_ff       <= pos_in;
         front_ff     <= front_in;
         right_ff     <= right_in;
         dy_ff        <= dy_in;
         dir_ff       <= dir_in;
         acc_ff       <= acc_in;
         ash_ff       <= ash_in;
         bsh_ff       <= bsh_in;
         mcnt_ff      <= mcnt_in;
         wr_ff        <= wr_in;
         cx_ff        <= cx_in;
         cyv_ff       <= cyv_in;
         cz_ff        <= cz_in;
         it_ff        <= it_in;
         cpass_ff     <= cpass_in;
         neg_ff       <= neg_in;
         cy_ff        <= cy_in;
         sy_ff        <= sy_in;
         cp_ff        <= cp_in;
         sp_ff        <= sp_in;
         vel_ff       <= vel_in;
         axis_ff      <= axis_in;
         opos_ff      <= opos_in;
         ofront_ff    <= ofront_in;
         ozoom_ff     <= ozoom_in;
         opitch_ff    <= opitch_in;
         oyaw_ff      <= oyaw_in;
      end
   end

endmodule
`default_nettype wire

/* design/ecpu_checker.sv */
// port-level assertions of the camera pose block and their bind
`default_nettype none
`include "euler_camera_pose_update_assert.svh"
module ecpu_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [13:0]        rsp_zoom,
   input wire logic signed [15:0] rsp_pitch
);

   `ECPU_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid)
   `ECPU_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `ECPU_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ECPU_ASSERT_IMPLY(a_zoom_range, clock, reset, rsp_valid,
      rsp_zoom >= 14'd256 && rsp_zoom <= 14'd11520)
   `ECPU_ASSERT_IMPLY(a_pitch_range, clock, reset, rsp_valid,
      rsp_pitch >= -16'sd22784 && rsp_pitch <= 16'sd22784)

endmodule

bind euler_camera_pose_update ecpu_checker u_ecpu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_zoom  (rsp_ch.zoom_deg),
   .rsp_pitch (rsp_ch.pitch_deg)
);
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench of the camera pose block with its own fixed-point pose predictor
`default_nettype none
module testbench;

   typedef struct {
      ecpu_pkg::cmd_type  cmd;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [15:0]        delta_time;
      logic [2:0]         direction;
   } cam_event_type;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic [13:0]        zoom_deg;
      logic signed [15:0] pitch_deg;
      logic signed [16:0] yaw_deg;
   } cam_pose_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint ATAN_DEG_Q20 [16] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833
   };

   logic clock;
   logic reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ecpu_req_if req_ch ();
   ecpu_rsp_if rsp_ch ();

   euler_camera_pose_update dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted camera state and register copies
   longint cam_yaw, cam_pitch, cam_zoom;
   longint cam_pos [3];
   longint cam_front [3];
   longint cam_right [2];
   longint cfg_speed, cfg_sens, cfg_fps;
   longint cfg_start [3];

   cam_pose_type expected_poses [$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      rsp_idle_pct = 0;
   int      quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic rotate_sincos(input longint ang, output longint c, output longint s);
      longint x, y, z, nx;
      x = 163008219;
      y = 0;
      z = ang * (64'sd1 <<< (20 - ecpu_pkg::ANGLE_FRAC_BITS));
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_DEG_Q20[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_DEG_Q20[i];
         end
         x = nx;
      end
      c = clamp_range(round_shift(x, 14), -16384, 16384);
      s = clamp_range(round_shift(y, 14), -16384, 16384);
   endtask

   task automatic refresh_view_vectors();
      longint a, q, cy, sy, cp, sp;
      bit flip;
      a = cam_yaw;
      q = 90 <<< ecpu_pkg::ANGLE_FRAC_BITS;
      flip = 0;
      if (a > q) begin
         a -= 2 * q;
         flip = 1;
      end else if (a < -q) begin
         a += 2 * q;
         flip = 1;
      end
      rotate_sincos(a, cy, sy);
      if (flip) begin
         cy = -cy;
         sy = -sy;
      end
      rotate_sincos(cam_pitch, cp, sp);
      cam_front[0] = clamp_range(round_shift(cy * cp, 14), -16384, 16384);
      cam_front[1] = sp;
      cam_front[2] = clamp_range(round_shift(sy * cp, 14), -16384, 16384);
      cam_right[0] = -sy;
      cam_right[1] = cy;
   endtask

   task automatic restore_pose();
      cam_yaw = -(90 <<< ecpu_pkg::ANGLE_FRAC_BITS);
      cam_pitch = 0;
      cam_zoom = 40 <<< ecpu_pkg::ANGLE_FRAC_BITS;
      for (int i = 0; i < 3; i++) cam_pos[i] = cfg_start[i];
      cam_front = '{0, 0, -16384};
      cam_right = '{16384, 0};
   endtask

   task automatic shift_axis(int idx, longint unit_q14, longint vel, bit sub);
      longint d;
      d = round_shift(unit_q14 * vel, 30 - ecpu_pkg::POS_FRAC_BITS);
      cam_pos[idx] = clamp_range(sub ? cam_pos[idx] - d : cam_pos[idx] + d,
                                 -64'sd2147483648, 64'sd2147483647);
   endtask

   task automatic predict_pose(input cam_event_type ev, output cam_pose_type p);
      longint ox, oy, yw, vel, span, half, lim;
      bit sub;
      span = 360 <<< ecpu_pkg::ANGLE_FRAC_BITS;
      half = 180 <<< ecpu_pkg::ANGLE_FRAC_BITS;
      lim = 89 <<< ecpu_pkg::ANGLE_FRAC_BITS;
      case (ev.cmd)
         ecpu_pkg::CMD_MOUSE: begin
            ox = round_shift(longint'(ev.dx) * cfg_sens, 20 - ecpu_pkg::ANGLE_FRAC_BITS);
            oy = round_shift(longint'(ev.dy) * cfg_sens, 20 - ecpu_pkg::ANGLE_FRAC_BITS);
            yw = (cam_yaw - ox + half) % span;
            if (yw < 0) yw += span;
            cam_yaw = yw - half;
            cam_pitch = clamp_range(cam_pitch - oy, -lim, lim);
            refresh_view_vectors();
         end
         ecpu_pkg::CMD_SCROLL: begin
            cam_zoom = clamp_range(
               cam_zoom - longint'(ev.dy) * (1 <<< (ecpu_pkg::ANGLE_FRAC_BITS - 4)),
               1 <<< ecpu_pkg::ANGLE_FRAC_BITS, 45 <<< ecpu_pkg::ANGLE_FRAC_BITS);
            refresh_view_vectors();
         end
         ecpu_pkg::CMD_KEY: begin
            vel = longint'(ev.delta_time) * cfg_speed;
            sub = ev.direction[0];
            if (ev.direction <= ecpu_pkg::DIR_BACKWARD) begin
               shift_axis(0, cam_front[0], vel, sub);
               if (cfg_fps == 0) shift_axis(1, cam_front[1], vel, sub);
               shift_axis(2, cam_front[2], vel, sub);
            end else if (ev.direction <= ecpu_pkg::DIR_LEFT) begin
               shift_axis(0, cam_right[0], vel, sub);
               shift_axis(2, cam_right[1], vel, sub);
            end else if (ev.direction <= ecpu_pkg::DIR_DOWN) begin
               shift_axis(1, 16384, vel, sub);
            end
         end
         default: restore_pose();
      endcase
      p.pos_x = 32'(cam_pos[0]);
      p.pos_y = 32'(cam_pos[1]);
      p.pos_z = 32'(cam_pos[2]);
      p.front_x = 16'(cam_front[0]);
      p.front_y = 16'(cam_front[1]);
      p.front_z = 16'(cam_front[2]);
      p.zoom_deg = 14'(cam_zoom);
      p.pitch_deg = 16'(cam_pitch);
      p.yaw_deg = 17'(cam_yaw);
   endtask

   task automatic hold_off_req();
      req_ch.valid <= 1'b0;
   endtask

   // valid is left high after a transfer; callers lower it before any wait
   task automatic send_event(input cam_event_type ev);
      cam_pose_type p;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= ev.cmd;
      req_ch.dx <= ev.dx;
      req_ch.dy <= ev.dy;
      req_ch.delta_time <= ev.delta_time;
      req_ch.direction <= ev.direction;
      do @(posedge clock); while (!req_ch.ready);
      predict_pose(ev, p);
      expected_poses.push_back(p);
   endtask

   task automatic send_fields(ecpu_pkg::cmd_type c, int dx, int dy, int dt, int dir);
      cam_event_type ev;
      ev.cmd = c;
      ev.dx = 16'(dx);
      ev.dy = 16'(dy);
      ev.delta_time = 16'(dt);
      ev.direction = 3'(dir);
      send_event(ev);
   endtask

   task automatic wait_drained();
      hold_off_req();
      while (expected_poses.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         ecpu_pkg::REG_MOVE_SPEED: cfg_speed = value[7:0];
         ecpu_pkg::REG_SENS:       cfg_sens = value[15:0];
         ecpu_pkg::REG_FPS_MODE:   cfg_fps = value[0];
         ecpu_pkg::REG_START_X:    cfg_start[0] = longint'($signed(value));
         ecpu_pkg::REG_START_Y:    cfg_start[1] = longint'($signed(value));
         ecpu_pkg::REG_START_Z:    cfg_start[2] = longint'($signed(value));
         default: ;
      endcase
   endtask

   task automatic write_all_regs(int speed, int sens, int fps, int sx, int sy, int sz);
      write_reg(ecpu_pkg::REG_MOVE_SPEED, 32'(speed));
      write_reg(ecpu_pkg::REG_SENS, 32'(sens));
      write_reg(ecpu_pkg::REG_FPS_MODE, 32'(fps));
      write_reg(ecpu_pkg::REG_START_X, 32'(sx));
      write_reg(ecpu_pkg::REG_START_Y, 32'(sy));
      write_reg(ecpu_pkg::REG_START_Z, 32'(sz));
   endtask

   function automatic cam_event_type random_event();
      cam_event_type ev;
      int r;
      r = $urandom_range(0, 99);
      ev.cmd = r < 40 ? ecpu_pkg::CMD_MOUSE :
               (r < 55 ? ecpu_pkg::CMD_SCROLL :
               (r < 94 ? ecpu_pkg::CMD_KEY : ecpu_pkg::CMD_RESTART));
      if ($urandom_range(0, 1)) begin
         ev.dx = 16'($urandom);
         ev.dy = 16'($urandom);
      end else begin
         ev.dx = 16'(int'($urandom_range(0, 1023)) - 512);
         ev.dy = 16'(int'($urandom_range(0, 1023)) - 512);
      end
      ev.delta_time = 16'($urandom);
      ev.direction = 3'($urandom_range(0, 7));
      return ev;
   endfunction

   task automatic test_reset_pose();
      send_fields(ecpu_pkg::CMD_KEY, 0, 0, 0, ecpu_pkg::DIR_FORWARD);
      send_fields(ecpu_pkg::CMD_SCROLL, 0, 0, 0, 0);
      wait_drained();
   endtask

   task automatic test_directed_events();
      send_fields(ecpu_pkg::CMD_MOUSE, 32767, 32767, 0, 0);
      send_fields(ecpu_pkg::CMD_MOUSE, -32768, -32768, 0, 0);
      send_fields(ecpu_pkg::CMD_MOUSE, 0, 0, 0, 0);
      send_fields(ecpu_pkg::CMD_MOUSE, 700, -300, 0, 0);
      send_fields(ecpu_pkg::CMD_MOUSE, -1400, 0, 0, 0);
      send_fields(ecpu_pkg::CMD_SCROLL, 0, -32768, 0, 0);
      send_fields(ecpu_pkg::CMD_SCROLL, 0, 32767, 0, 0);
      send_fields(ecpu_pkg::CMD_SCROLL, 0, -16, 0, 0);
      for (int d = 0; d < 8; d++) send_fields(ecpu_pkg::CMD_KEY, 0, 0, 65535, d);
      send_fields(ecpu_pkg::CMD_KEY, -1, -1, 0, ecpu_pkg::DIR_FORWARD);
      send_fields(ecpu_pkg::CMD_RESTART, 0, 0, 0, 0);
      wait_drained();
   endtask

   task automatic test_position_saturation();
      write_all_regs(255, 65535, 1, 32'h7FFF_FF00, 32'h8000_0100, 32'h7FFF_0000);
      write_reg(3'd6, 32'hFFFF_FFFF);
      write_reg(3'd7, 32'hFFFF_FFFF);
      send_fields(ecpu_pkg::CMD_RESTART, 0, 0, 0, 0);
      send_fields(ecpu_pkg::CMD_KEY, 0, 0, 65535, ecpu_pkg::DIR_RIGHT);
      send_fields(ecpu_pkg::CMD_KEY, 0, 0, 65535, ecpu_pkg::DIR_DOWN);
      send_fields(ecpu_pkg::CMD_KEY, 0, 0, 65535, ecpu_pkg::DIR_BACKWARD);
      send_fields(ecpu_pkg::CMD_MOUSE, 20, 40, 0, 0);
      send_fields(ecpu_pkg::CMD_KEY, 0, 0, 65535, ecpu_pkg::DIR_FORWARD);
      wait_drained();
   endtask

   task automatic test_random_events(int tx_idle, int rx_idle, int count, bit pause_once);
      send_idle_pct = tx_idle;
      rsp_idle_pct = rx_idle;
      send_fields(ecpu_pkg::CMD_RESTART, 0, 0, 0, 0);
      for (int i = 0; i < count; i++) begin
         if (pause_once && i == count / 2) wait_drained();
         send_event(random_event());
      end
      wait_drained();
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // response checking
   always @(posedge clock) begin
      cam_pose_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_poses.size() == 0) begin
            $error("pose transfer with nothing expected");
            error_count++;
         end else begin
            e = expected_poses.pop_front();
            check_field("pos_x", e.pos_x, rsp_ch.pos_x);
            check_field("pos_y", e.pos_y, rsp_ch.pos_y);
            check_field("pos_z", e.pos_z, rsp_ch.pos_z);
            check_field("front_x", e.front_x, rsp_ch.front_x);
            check_field("front_y", e.front_y, rsp_ch.front_y);
            check_field("front_z", e.front_z, rsp_ch.front_z);
            check_field("zoom_deg", e.zoom_deg, rsp_ch.zoom_deg);
            check_field("pitch_deg", e.pitch_deg, rsp_ch.pitch_deg);
            check_field("yaw_deg", e.yaw_deg, rsp_ch.yaw_deg);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || csr_psel || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = ecpu_pkg::CMD_MOUSE;
      req_ch.dx = '0;
      req_ch.dy = '0;
      req_ch.delta_time = '0;
      req_ch.direction = ecpu_pkg::DIR_FORWARD;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg_speed = ecpu_pkg::SPEED_RESET;
      cfg_sens = ecpu_pkg::SENS_RESET;
      cfg_fps = 0;
      cfg_start = '{0, 0, 0};
      restore_pose();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_pose();
      test_directed_events();
      test_position_saturation();
      write_all_regs(0, 65535, 0, $urandom, $urandom, $urandom);
      test_random_events(18, 83, 130, 1);
      write_all_regs(255, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      test_random_events(83, 18, 130, 0);
      write_all_regs($urandom_range(1, 254), $urandom_range(200, 20000), 0,
                     $urandom, $urandom, $urandom);
      test_random_events(0, 0, 140, 0);

      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_poses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+design
design/ecpu_pkg.sv
design/ecpu_if.sv
design/euler_camera_pose_update.sv
design/ecpu_checker.sv
tb/testbench.sv
